[design/assert_macros.svh]
// assertion macros shared by the parser rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[design/ifp_pkg.sv]
// types and constants of the frame parser
// no dependencies
`default_nettype none

package ifp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int POS_W     = 4;

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(FRAME_LEN - 1);

  // byte positions of the low bytes of the four words
  localparam int POS_WORD_A = 2;
  localparam int POS_WORD_B = 4;
  localparam int POS_WORD_C = 6;
  localparam int POS_WORD_D = 8;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER   = 2'd0,
    CFG_TYPE_MIN = 2'd1,
    CFG_TYPE_MAX = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] HEADER_RESET   = 8'h55;
  localparam logic [7:0] TYPE_MIN_RESET = 8'h50;
  localparam logic [7:0] TYPE_MAX_RESET = 8'h5F;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_TYPE = 2'd1,
    STATUS_SUM  = 2'd2
  } status_t;

  // one accepted byte tagged with its frame position
  typedef struct packed {
    logic [7:0]       rx_byte;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic [7:0] type_min;
    logic [7:0] type_max;
  } type_range_t;

endpackage

`default_nettype wire

[design/ifp_if.sv]
// valid/ready channel interfaces of the frame parser
// depends on ifp_pkg
`default_nettype none

interface ifp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifp_frame_if;
  import ifp_pkg::*;
  logic        valid;
  logic        ready;
  status_t     frame_status;
  logic [7:0]  frame_type;
  logic signed [15:0] word_a;
  logic signed [15:0] word_b;
  logic signed [15:0] word_c;
  logic signed [15:0] word_d;

  modport source (output valid, output frame_status, output frame_type,
                  output word_a, output word_b, output word_c, output word_d,
                  input ready);
  modport sink (input valid, input frame_status, input frame_type,
                input word_a, input word_b, input word_c, input word_d,
                output ready);
endinterface

interface ifp_cfg_if;
  import ifp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/imu_uart_frame_parser.sv]
// top level of the serial frame parser: config registers, front end, queue, back end
// depends on ifp_pkg, ifp_if, ifp_front, ifp_queue, ifp_back
`default_nettype none

// Takes one received byte per cycle on rx and emits one result per completed
// eleven-byte frame on result (status, type byte, four little-endian signed words).
// Bytes arriving at position 0 that do not match header_value are dropped.
// Sustained rate is one byte per cycle while the queue is not full. The front tags
// the last byte of a frame and the queue stores it at the accepting edge; the back
// end checks it into the result register when it pops it. The queue of QUEUE_DEPTH
// entries lets the front keep taking bytes while a result waits on result.ready.
// Config writes on cfg complete in the cycle they are presented; indexes beyond
// type_max are ignored. There is no clearing pass after reset.
module imu_uart_frame_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  ifp_byte_if.sink     rx,
  ifp_frame_if.source  result,
  ifp_cfg_if.sink      cfg
);
  import ifp_pkg::*;

  logic        [7:0] header_value;
  type_range_t       type_range;
  logic              push;
  entry_t            push_entry;
  logic              q_not_full;
  logic              q_not_empty;
  logic              pop;
  entry_t            head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value        <= HEADER_RESET;
      type_range.type_min <= TYPE_MIN_RESET;
      type_range.type_max <= TYPE_MAX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_HEADER:   header_value        <= cfg.data;
        CFG_TYPE_MIN: type_range.type_min <= cfg.data;
        CFG_TYPE_MAX: type_range.type_max <= cfg.data;
        default: ;
      endcase
    end
  end

  ifp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .header_value (header_value),
    .q_ready      (q_not_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  ifp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .head       (head)
  );

  ifp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .head       (head),
    .pop        (pop),
    .type_range (type_range),
    .result     (result)
  );

endmodule

`default_nettype wire

[design/ifp_front.sv]
// front end: accepts bytes, drops stray bytes before a header, tags each kept byte
// with its frame position; depends on ifp_pkg, ifp_if, assert_macros.svh
`default_nettype none

module ifp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ifp_byte_if.sink           rx,
  input  wire logic [7:0]    header_value,
  input  wire logic          q_ready,
  output logic               push,
  output ifp_pkg::entry_t    push_entry
);
  import ifp_pkg::*;

  `include "assert_macros.svh"

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             accept;
  logic             drop;

  assign rx.ready = q_ready;
  assign accept   = rx.valid && rx.ready;
  assign drop     = (pos == POS_HEADER) && (rx.rx_byte != header_value);
  assign push     = accept && !drop;

  assign push_entry.rx_byte = rx.rx_byte;
  assign push_entry.pos     = pos;

  always_comb begin
    pos_next = pos;
    if (push) begin
      pos_next = (pos == POS_CHECK) ? POS_HEADER : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HEADER;
    end else begin
      pos <= pos_next;
    end
  end

  `ASSERT_NEXT(a_wrap_after_check, clk, rst, push && (pos == POS_CHECK), pos == POS_HEADER, "position did not wrap after checksum byte")
  `ASSERT_IMPLY(a_pos_in_frame, clk, rst, 1'b1, pos <= POS_CHECK, "position beyond frame")

endmodule

`default_nettype wire

[design/ifp_queue.sv]
// short fifo of tagged bytes between front and back end
// depends on ifp_pkg, assert_macros.svh
`default_nettype none

module ifp_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire ifp_pkg::entry_t push_entry,
  output logic            not_full,
  output logic            not_empty,
  input  wire logic       pop,
  output ifp_pkg::entry_t head
);
  import ifp_pkg::*;

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, not_full, "push into full queue")
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, not_empty, "pop from empty queue")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

[design/ifp_back.sv]
// back end: stores frame bytes, keeps the running sum, checks type and checksum
// and holds the result register; depends on ifp_pkg, ifp_if, assert_macros.svh
`default_nettype none

module ifp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ifp_pkg::entry_t head,
  output logic               pop,
  input  wire ifp_pkg::type_range_t type_range,
  ifp_frame_if.source        result
);
  import ifp_pkg::*;

  `include "assert_macros.svh"

  // bytes from the type byte up to the last data byte
  logic [7:0] frame_bytes [POS_TYPE:POS_CHECK-POS_W'(1)];
  logic [7:0] running_sum;
  logic       out_valid;
  logic       is_last;
  logic       is_body;
  logic       type_bad;
  logic       sum_bad;
  status_t    status_next;

  assign is_last = (head.pos == POS_CHECK);
  assign is_body = (head.pos >= POS_TYPE) && (head.pos < POS_CHECK);
  assign pop     = q_valid && (!is_last || !out_valid || result.ready);

  assign type_bad = (frame_bytes[POS_TYPE] < type_range.type_min) ||
                    (frame_bytes[POS_TYPE] > type_range.type_max);
  assign sum_bad  = (running_sum != head.rx_byte);

  always_comb begin
    if (type_bad) begin
      status_next = STATUS_TYPE;
    end else if (sum_bad) begin
      status_next = STATUS_SUM;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_body) begin
      frame_bytes[head.pos] <= head.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && !is_last) begin
        running_sum <= (head.pos == POS_HEADER) ? head.rx_byte : running_sum + head.rx_byte;
      end
      if (pop && is_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_last) begin
      result.frame_status <= status_next;
      result.frame_type   <= frame_bytes[POS_TYPE];
      result.word_a <= {frame_bytes[POS_WORD_A + 1], frame_bytes[POS_WORD_A]};
      result.word_b <= {frame_bytes[POS_WORD_B + 1], frame_bytes[POS_WORD_B]};
      result.word_c <= {frame_bytes[POS_WORD_C + 1], frame_bytes[POS_WORD_C]};
      result.word_d <= {frame_bytes[POS_WORD_D + 1], frame_bytes[POS_WORD_D]};
    end
  end

  assign result.valid = out_valid;

  `ASSERT_IMPLY(a_no_result_overwrite, clk, rst, pop && is_last && out_valid,
                result.ready, "result overwritten while waiting")
  `ASSERT_NEXT(a_result_raised, clk, rst, pop && is_last, out_valid,
               "frame end did not raise result")
  `ASSERT_IMPLY(a_status_code, clk, rst, out_valid, result.frame_status != 2'd3,
                "undefined status code")

endmodule

`default_nettype wire
